[rtl/core/spr_pkg.sv]
package spr_pkg;

	localparam int WIDTH_BITS = 15;
	localparam int COUNT_BITS = 16;
	localparam int PWM_PRESCALE = 2;

	localparam int CMP_BITS      = 16;
	localparam int CDIV_BITS     = $clog2(PWM_PRESCALE + 1);
	localparam int DIVIDEND_BITS = WIDTH_BITS + COUNT_BITS;
	localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);
	localparam int MODE_BITS     = 3;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = (WIDTH_BITS > COUNT_BITS) ? WIDTH_BITS : COUNT_BITS;
	localparam int S_TDATA_BITS  = ((WIDTH_BITS + 7) / 8) * 8;
	localparam int M_FIELD_BITS  = WIDTH_BITS + CMP_BITS + 2;
	localparam int M_TDATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

	localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_RESET = '1;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_FORCE  = 3'd0,
		MODE_SMOOTH = 3'd1,
		MODE_TICK   = 3'd2,
		MODE_START  = 3'd3,
		MODE_STOP   = 3'd4,
		MODE_READ   = 3'd5
	} mode_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MIN_WIDTH  = 2'd0,
		CFG_MAX_WIDTH  = 2'd1,
		CFG_REST_WIDTH = 2'd2,
		CFG_RAMP_TICKS = 2'd3
	} cfg_idx_t;

endpackage

[rtl/core/spr_div.sv]
module spr_div
	import spr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DIVIDEND_BITS-1:0] dividend,
	input  logic [COUNT_BITS-1:0]    divisor,
	output logic                     done,
	output logic [DIVIDEND_BITS-1:0] quotient
);

	logic [DIVIDEND_BITS-1:0] dvd_q;
	logic [COUNT_BITS-1:0]    rem_q;
	logic [COUNT_BITS-1:0]    dsr_q;
	logic [DIV_CNT_BITS-1:0]  cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [COUNT_BITS:0]      rem_sh;
	logic [COUNT_BITS+1:0]    trial;
	logic                     neg;

	// one restoring step per cycle through the shared subtractor
	assign rem_sh = {rem_q, dvd_q[DIVIDEND_BITS-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, dsr_q};
	assign neg    = trial[COUNT_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_BITS'(DIVIDEND_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= neg ? rem_sh[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			dvd_q <= {dvd_q[DIVIDEND_BITS-2:0], ~neg};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

[rtl/core/servo_pulse_ramp_unit.sv]
// Sequence: force, smooth target, start, stop, read and ticks that take no step pass from
//   ST_EVAL to ST_DONE and raise m_tvalid on the commit; a tick that takes a ramp step goes
//   through ST_LAUNCH and ST_DIV first (the serial divider takes one quotient bit per cycle).
// Flow: one item at a time; a result still held by m_tready low delays the next commit.
// Reset: arst_n clears the widths, ramp state and output valid; generator enabled, full
//   clamp range, one-tick ramp.
module servo_pulse_ramp_unit
	import spr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// slave side: command items
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [S_TDATA_BITS-1:0]  s_tdata,   // [14:0] target_width
	input  logic [MODE_BITS-1:0]     s_tuser,   // [2:0] mode
	// master side: result items
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [M_TDATA_BITS-1:0]  m_tdata,   // [14:0] width_now, [30:15] compare_value,
	                                            // [31] width_written, [32] generator_on
	// configuration write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_LAUNCH,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [WIDTH_BITS-1:0] min_width_q;
	logic [WIDTH_BITS-1:0] max_width_q;
	logic [WIDTH_BITS-1:0] rest_width_q;
	logic [COUNT_BITS-1:0] ramp_ticks_q;

	// servo state
	logic [WIDTH_BITS-1:0] ramp_start_q;
	logic [WIDTH_BITS-1:0] ramp_target_q;
	logic [WIDTH_BITS-1:0] width_q;
	logic [COUNT_BITS-1:0] tick_count_q;
	logic                  gen_enable_q;

	// captured command and step working registers
	mode_t                    mode_q;
	logic [WIDTH_BITS-1:0]    tw_q;
	logic                     step_q;
	logic                     down_q;
	logic [DIVIDEND_BITS-1:0] prod_q;
	logic [WIDTH_BITS-1:0]    quot_q;

	// output register
	logic                    m_tvalid_q;
	logic [M_TDATA_BITS-1:0] m_tdata_q;

	logic                     in_xfer;
	logic                     out_load;
	logic                     div_start;
	logic                     div_done;
	logic [DIVIDEND_BITS-1:0] div_quot;

	logic                  step_ok;
	logic                  down;
	logic [WIDTH_BITS-1:0] diff;
	logic [COUNT_BITS-1:0] k_next;

	logic [WIDTH_BITS-1:0] ramp_v;
	logic [WIDTH_BITS-1:0] ramp_clamped;

	logic [WIDTH_BITS-1:0] width_d;
	logic [WIDTH_BITS-1:0] start_d;
	logic [WIDTH_BITS-1:0] target_d;
	logic [COUNT_BITS-1:0] count_d;
	logic                  gen_d;
	logic                  written_d;
	logic [WIDTH_BITS+CDIV_BITS-1:0] cmp_full;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	// commit only once the previous result has been taken or is being taken now
	assign out_load  = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	assign div_start = (state_q == ST_LAUNCH);

	// a tick steps while the count is short of the ramp length and the width is off target;
	// a ramp length of zero never steps, so, set only while idle, it never becomes the divisor
	assign step_ok = (tick_count_q < ramp_ticks_q) && (width_q != ramp_target_q);
	assign down    = ramp_target_q < ramp_start_q;
	assign diff    = down ? (ramp_start_q - ramp_target_q) : (ramp_target_q - ramp_start_q);
	assign k_next  = tick_count_q + 1'b1;

	spr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (ramp_ticks_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// the quotient never exceeds the span, so the step stays inside the word
	assign ramp_v = down_q ? (ramp_start_q - quot_q) : (ramp_start_q + quot_q);

	// lower clamp is checked first; with inverted clamps a value below it takes it, any other the upper
	always_comb begin
		priority if (ramp_v < min_width_q) begin
			ramp_clamped = min_width_q;
		end else if (ramp_v > max_width_q) begin
			ramp_clamped = max_width_q;
		end else begin
			ramp_clamped = ramp_v;
		end
	end

	// next servo state for the captured command
	always_comb begin
		width_d   = width_q;
		start_d   = ramp_start_q;
		target_d  = ramp_target_q;
		count_d   = tick_count_q;
		gen_d     = gen_enable_q;
		written_d = 1'b0;
		unique case (mode_q)
			MODE_FORCE: begin
				width_d   = tw_q;
				start_d   = tw_q;
				target_d  = tw_q;
				written_d = 1'b1;
			end
			MODE_SMOOTH: begin
				// restart from the present width only when the target moves
				if (tw_q != ramp_target_q) begin
					start_d = width_q;
					count_d = '0;
				end
				target_d = tw_q;
			end
			MODE_TICK: begin
				if (step_q) begin
					width_d   = ramp_clamped;
					count_d   = tick_count_q + 1'b1;
					written_d = 1'b1;
				end
			end
			MODE_START: begin
				gen_d     = 1'b1;
				width_d   = rest_width_q;
				start_d   = rest_width_q;
				target_d  = rest_width_q;
				written_d = 1'b1;
			end
			MODE_STOP: begin
				gen_d = 1'b0;
			end
			default: begin
				// read and the unused codes only report
			end
		endcase
	end

	assign cmp_full = {{CDIV_BITS{1'b0}}, width_d} * (WIDTH_BITS + CDIV_BITS)'(PWM_PRESCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			min_width_q   <= '0;
			max_width_q   <= MAX_WIDTH_RESET;
			rest_width_q  <= '0;
			ramp_ticks_q  <= COUNT_BITS'(1);
			ramp_start_q  <= '0;
			ramp_target_q <= '0;
			width_q       <= '0;
			tick_count_q  <= '0;
			gen_enable_q  <= 1'b1;
			m_tvalid_q    <= 1'b0;
		end else begin
			// configuration transfers must arrive only while the unit is idle; the unit does not enforce it
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_MIN_WIDTH:  min_width_q  <= cfg_data[WIDTH_BITS-1:0];
					CFG_MAX_WIDTH:  max_width_q  <= cfg_data[WIDTH_BITS-1:0];
					CFG_REST_WIDTH: rest_width_q <= cfg_data[WIDTH_BITS-1:0];
					CFG_RAMP_TICKS: ramp_ticks_q <= cfg_data[COUNT_BITS-1:0];
					default: ;
				endcase
			end

			// raise valid on a commit, drop it once the result transfer is done
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					// hand a stepping tick to the divider, settle the rest directly
					state_q <= (step_q) ? ST_LAUNCH : ST_DONE;
				end
				ST_LAUNCH: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						width_q       <= width_d;
						ramp_start_q  <= start_d;
						ramp_target_q <= target_d;
						tick_count_q  <= count_d;
						gen_enable_q  <= gen_d;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mode_q <= mode_t'(s_tuser);
			tw_q   <= s_tdata[WIDTH_BITS-1:0];
			step_q <= (mode_t'(s_tuser) == MODE_TICK) && step_ok;
			down_q <= down;
		end
		if (state_q == ST_EVAL) begin
			prod_q <= {{COUNT_BITS{1'b0}}, diff} * {{WIDTH_BITS{1'b0}}, k_next};
		end
		if (div_done) begin
			quot_q <= div_quot[WIDTH_BITS-1:0];
		end
		if (out_load) begin
			m_tdata_q <= M_TDATA_BITS'({gen_d, written_d, cmp_full[CMP_BITS-1:0], width_d});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// a taken command always leaves idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q != ST_IDLE))
		else $error("command transfer did not start processing");

	// the divider answers only a launched step
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// a ramp quotient always fits a pulse width
	a_quot_fits: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (div_quot[DIVIDEND_BITS-1:WIDTH_BITS] == '0))
		else $error("ramp quotient wider than a pulse width");

	// a committed step never runs the count past the ramp length
	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (mode_q == MODE_TICK) && step_q) |-> (tick_count_q < ramp_ticks_q))
		else $error("ramp step committed beyond ramp length");

endmodule
